FILE: src/mdg_pkg.sv
// Package for the maze DFS generator: grid constants, item and cell types,
// sequencer states and small helper functions. No dependencies.
package mdg_pkg;

  localparam int GRID_SIDE  = 16;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int RW         = $clog2(GRID_SIDE);
  localparam int CW         = $clog2(CELL_COUNT);
  localparam int DW         = $clog2(CELL_COUNT + 1);

  typedef logic [RW-1:0] coord_t;
  typedef logic [CW-1:0] idx_t;
  typedef logic [DW-1:0] depth_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } cell_t;

  localparam coord_t COORD_MAX = coord_t'(GRID_SIDE - 1);

  // item kinds
  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] random_word;
    logic [3:0]  query_row;
    logic [3:0]  query_col;
  } in_item_t;

  typedef struct packed {
    logic [3:0] from_row;
    logic [3:0] from_col;
    logic [3:0] to_row;
    logic [3:0] to_col;
    logic       carved;
    logic       finished;
    logic       right_wall;
    logic       down_wall;
  } out_item_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // neighbour unit results
  typedef struct packed {
    logic  in_grid;
    cell_t nb;
    idx_t  nb_idx;
    idx_t  cur_idx;
  } nbr_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_RST_FIN,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DECIDE,
    ST_POP_RD,
    ST_POP_LD,
    ST_READ_WAIT,
    ST_EMIT
  } state_t;

  function automatic idx_t cell_idx(cell_t c);
    logic [CW+RW-1:0] prod;
    prod = {{CW{1'b0}}, c.row} * (CW + RW)'(GRID_SIDE) + {{CW{1'b0}}, c.col};
    return prod[CW-1:0];
  endfunction

  // low four bits of a coordinate, zero extended on small grids
  function automatic logic [3:0] nib(coord_t v);
    logic [RW+3:0] ext;
    ext = {4'b0000, v};
    return ext[3:0];
  endfunction

  // fit a 4-bit query coordinate to grid width (only used when in range)
  function automatic coord_t fit_coord(logic [3:0] v);
    logic [RW+3:0] ext;
    ext = {{RW{1'b0}}, v};
    return ext[RW-1:0];
  endfunction

  // v mod 3 via base-4 digit sum (4 = 1 mod 3)
  function automatic logic [1:0] mod3_15(logic [14:0] v);
    logic [15:0] ve;
    logic [4:0]  s;
    logic [2:0]  t;
    ve = {1'b0, v};
    s  = 5'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'b000, ve[2*i +: 2]};
    end
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // direction of the k-th set bit of the open mask, order left..up
  function automatic dir_t pick_dir(logic [3:0] mask, logic [1:0] k);
    logic [1:0] cnt;
    logic       found;
    dir_t       sel;
    cnt   = 2'd0;
    found = 1'b0;
    sel   = DIR_LEFT;
    for (int d = 0; d < 4; d++) begin
      if (mask[d] && !found) begin
        if (cnt == k) begin
          sel   = dir_t'(2'(d));
          found = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
    return sel;
  endfunction

endpackage

FILE: src/mdg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mdg_nbr_unit.sv
// Shared neighbour unit: steps a cell one place in a direction, checks the
// grid edge and forms RAM addresses. Depends on mdg_pkg.
module mdg_nbr_unit (
  input  mdg_pkg::cell_t    cur,
  input  mdg_pkg::dir_t     dir,
  output mdg_pkg::nbr_res_t res
);
  import mdg_pkg::*;

  cell_t nb;
  logic  ok;

  always_comb begin
    nb = cur;
    ok = 1'b0;
    case (dir)
      DIR_LEFT: begin
        ok     = (cur.col != '0);
        nb.col = cur.col - coord_t'(1);
      end
      DIR_DOWN: begin
        ok     = (cur.row != COORD_MAX);
        nb.row = cur.row + coord_t'(1);
      end
      DIR_RIGHT: begin
        ok     = (cur.col != COORD_MAX);
        nb.col = cur.col + coord_t'(1);
      end
      DIR_UP: begin
        ok     = (cur.row != '0);
        nb.row = cur.row - coord_t'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign res.in_grid = ok;
  assign res.nb      = nb;
  assign res.nb_idx  = cell_idx(nb);
  assign res.cur_idx = cell_idx(cur);

endmodule

FILE: src/maze_dfs_generator_core.sv
// Maze DFS generator top level: sequencer, visited/wall/stack RAMs, output
// register. Depends on mdg_pkg, mdg_ram and mdg_nbr_unit.
//
// Builds a GRID_SIDE x GRID_SIDE maze with a randomized depth-first walk.
// Items are taken one at a time (in_ready high only when idle); one result
// per item. After reset, and on every restart item, a clearing pass writes
// visited=0 and all walls closed, one cell a cycle. An advance visits the
// four neighbours of the current cell one at a time through the single read
// port of the visited RAM, an in-grid neighbour through the scan read and
// scan check states and a grid edge through the scan read state alone; a
// carving step then adds the decide and emit states. Each backtrack pop adds
// the dead-end decision, the stack RAM read (pop read and pop load states)
// and a fresh neighbour scan. An advance on a finished maze or an unused
// kind goes straight to emit; a read item first waits for the wall RAM read.
// A result waits in the emit state while the output register is still full.
// A finished result sits in the output register while the next item may be
// accepted.
module maze_dfs_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mdg_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mdg_pkg::out_item_t  out_data
);
  import mdg_pkg::*;

  // sequencer and walk state
  state_t     state_r, state_nxt;
  logic       restart_r, restart_nxt;   // clearing pass belongs to a restart item
  idx_t       clr_r, clr_nxt;
  cell_t      cur_r, cur_nxt;
  depth_t     depth_r, depth_nxt;
  logic       done_r, done_nxt;
  dir_t       dir_r, dir_nxt;
  logic [3:0] mask_r, mask_nxt;         // unvisited neighbours, bit per dir
  logic       out_valid_r, out_valid_nxt;

  // payload
  logic [14:0] rnd_r, rnd_nxt;
  logic        q_ok_r, q_ok_nxt;
  out_item_t   res_r, res_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // neighbour unit
  dir_t       nbr_dir;
  nbr_res_t   nbr;
  dir_t       chosen;
  logic [2:0] open_cnt;
  logic [1:0] pick_k;
  depth_t     dep_m1;

  // RAM ports
  logic  vis_we, vis_wdata, vis_rdata;
  idx_t  vis_waddr, vis_raddr;
  logic  rw_we, rw_wdata, rw_rdata;
  idx_t  rw_waddr;
  logic  dw_we, dw_wdata, dw_rdata;
  idx_t  dw_waddr;
  idx_t  wall_raddr;
  logic  stk_we;
  idx_t  stk_waddr, stk_raddr;
  cell_t stk_wdata, stk_rdata;

  cell_t q_cell;
  logic  q_ok;

  mdg_nbr_unit u_nbr (
    .cur (cur_r),
    .dir (nbr_dir),
    .res (nbr)
  );

  mdg_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  mdg_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_right_walls (
    .clk(clk), .we(rw_we), .waddr(rw_waddr), .wdata(rw_wdata),
    .raddr(wall_raddr), .rdata(rw_rdata)
  );

  mdg_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_down_walls (
    .clk(clk), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata),
    .raddr(wall_raddr), .rdata(dw_rdata)
  );

  mdg_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELL_COUNT)) u_path_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // query cell; out-of-grid queries read as closed walls
  assign q_ok = ({{RW{1'b0}}, in_data.query_row} < (RW + 4)'(GRID_SIDE)) &&
                ({{RW{1'b0}}, in_data.query_col} < (RW + 4)'(GRID_SIDE));
  assign q_cell.row = fit_coord(in_data.query_row);
  assign q_cell.col = fit_coord(in_data.query_col);

  // random pick among open neighbours: rnd mod count
  assign open_cnt = 3'($countones(mask_r));
  always_comb begin
    case (open_cnt)
      3'd2:    pick_k = {1'b0, rnd_r[0]};
      3'd3:    pick_k = mod3_15(rnd_r);
      3'd4:    pick_k = rnd_r[1:0];
      default: pick_k = 2'd0;
    endcase
  end
  assign chosen  = pick_dir(mask_r, pick_k);
  assign nbr_dir = (state_r == ST_DECIDE) ? chosen : dir_r;
  assign dep_m1  = depth_r - depth_t'(1);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    restart_nxt   = restart_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    depth_nxt     = depth_r;
    done_nxt      = done_r;
    dir_nxt       = dir_r;
    mask_nxt      = mask_r;
    rnd_nxt       = rnd_r;
    q_ok_nxt      = q_ok_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    vis_we     = 1'b0;
    vis_waddr  = nbr.nb_idx;
    vis_wdata  = 1'b1;
    vis_raddr  = nbr.nb_idx;
    rw_we      = 1'b0;
    rw_waddr   = nbr.cur_idx;
    rw_wdata   = 1'b0;
    dw_we      = 1'b0;
    dw_waddr   = nbr.cur_idx;
    dw_wdata   = 1'b0;
    wall_raddr = cell_idx(q_cell);
    stk_we     = 1'b0;
    stk_waddr  = depth_r[CW-1:0];
    stk_wdata  = nbr.nb;
    stk_raddr  = dep_m1[CW-1:0];

    case (state_r)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wdata = 1'b0;
        rw_we     = 1'b1;
        rw_waddr  = clr_r;
        rw_wdata  = 1'b1;
        dw_we     = 1'b1;
        dw_waddr  = clr_r;
        dw_wdata  = 1'b1;
        clr_nxt   = clr_r + idx_t'(1);
        if (clr_r == idx_t'(CELL_COUNT - 1)) begin
          state_nxt = restart_r ? ST_RST_FIN : ST_IDLE;
        end
      end

      ST_RST_FIN: begin
        // cell 0,0 visited and the only stack entry
        vis_we      = 1'b1;
        vis_waddr   = '0;
        vis_wdata   = 1'b1;
        stk_we      = 1'b1;
        stk_waddr   = '0;
        stk_wdata   = '0;
        cur_nxt     = '0;
        depth_nxt   = depth_t'(1);
        done_nxt    = 1'b0;
        restart_nxt = 1'b0;
        res_nxt     = '0;
        state_nxt   = ST_EMIT;
      end

      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            KIND_RESTART: begin
              restart_nxt = 1'b1;
              clr_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            KIND_ADVANCE: begin
              rnd_nxt = in_data.random_word;
              if (done_r) begin
                res_nxt          = '0;
                res_nxt.finished = 1'b1;
                state_nxt        = ST_EMIT;
              end else begin
                dir_nxt   = DIR_LEFT;
                mask_nxt  = '0;
                state_nxt = ST_SCAN_RD;
              end
            end
            KIND_READ: begin
              q_ok_nxt  = q_ok;
              state_nxt = ST_READ_WAIT;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_SCAN_RD: begin
        if (nbr.in_grid) begin
          state_nxt = ST_SCAN_CHK;
        end else if (dir_r == DIR_UP) begin
          state_nxt = ST_DECIDE;
        end else begin
          dir_nxt = dir_t'(2'(dir_r + 2'd1));
        end
      end

      ST_SCAN_CHK: begin
        mask_nxt[dir_r] = ~vis_rdata;
        if (dir_r == DIR_UP) begin
          state_nxt = ST_DECIDE;
        end else begin
          dir_nxt   = dir_t'(2'(dir_r + 2'd1));
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_DECIDE: begin
        if (open_cnt == 3'd0) begin
          // dead end: pop, or finish when only the last stack entry is left
          if (depth_r <= depth_t'(1)) begin
            depth_nxt        = '0;
            done_nxt         = 1'b1;
            res_nxt          = '0;
            res_nxt.finished = 1'b1;
            state_nxt        = ST_EMIT;
          end else begin
            depth_nxt = dep_m1;
            state_nxt = ST_POP_RD;
          end
        end else begin
          vis_we = 1'b1;
          case (chosen)
            DIR_LEFT: begin
              rw_we    = 1'b1;
              rw_waddr = nbr.nb_idx;
            end
            DIR_RIGHT: begin
              rw_we = 1'b1;
            end
            DIR_DOWN: begin
              dw_we = 1'b1;
            end
            default: begin
              dw_we    = 1'b1;
              dw_waddr = nbr.nb_idx;
            end
          endcase
          if (depth_r < depth_t'(CELL_COUNT)) begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + depth_t'(1);
          end
          res_nxt          = '0;
          res_nxt.from_row = nib(cur_r.row);
          res_nxt.from_col = nib(cur_r.col);
          res_nxt.to_row   = nib(nbr.nb.row);
          res_nxt.to_col   = nib(nbr.nb.col);
          res_nxt.carved   = 1'b1;
          cur_nxt          = nbr.nb;
          state_nxt        = ST_EMIT;
        end
      end

      ST_POP_RD: begin
        // stack read of the new top is in flight
        state_nxt = ST_POP_LD;
      end

      ST_POP_LD: begin
        cur_nxt   = stk_rdata;
        dir_nxt   = DIR_LEFT;
        mask_nxt  = '0;
        state_nxt = ST_SCAN_RD;
      end

      ST_READ_WAIT: begin
        res_nxt            = '0;
        res_nxt.right_wall = q_ok_r ? rw_rdata : 1'b1;
        res_nxt.down_wall  = q_ok_r ? dw_rdata : 1'b1;
        state_nxt          = ST_EMIT;
      end

      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      restart_r   <= 1'b0;
      clr_r       <= '0;
      cur_r       <= '0;
      depth_r     <= '0;
      done_r      <= 1'b1;
      dir_r       <= DIR_LEFT;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      restart_r   <= restart_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      depth_r     <= depth_nxt;
      done_r      <= done_nxt;
      dir_r       <= dir_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    q_ok_r     <= q_ok_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/mdg_checker.sv
// Port-level checker for the maze DFS generator, bound to the top level.
// Depends on mdg_pkg and maze_dfs_generator_core.
module mdg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mdg_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mdg_pkg::out_item_t out_data
);
  import mdg_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a carved passage joins two distinct cells in one row or one column
  a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.carved |->
      ((out_data.from_row == out_data.to_row) != (out_data.from_col == out_data.to_col)))
    else $error("carved cells not adjacent");

  // a finish or wall read result carries no carve flag, from_row or to_col
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.right_wall || out_data.down_wall || out_data.finished) |->
      !out_data.carved && out_data.from_row == 4'd0 && out_data.to_col == 4'd0)
    else $error("mixed result fields");

endmodule

bind maze_dfs_generator_core mdg_checker u_mdg_checker (.*);
